// ===== rtl/ole_pkg.sv =====
// Shared types, codes and sizes of the ordered list engine.
package ole_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int VALUE_W = 32;
   localparam int KIND_W = 2;
   localparam int STATUS_W = 2;

   // Request kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH   = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_POP    = 2'd2,
      KIND_SEARCH = 2'd3
   } kind_type;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic set_full;
      logic set_empty;
      logic scan_start;
      logic scan_step;
      logic find_take;
      logic pos_zero;
      logic up_start;
      logic up_read;
      logic up_write;
      logic up_final;
      logic down_start;
      logic down_read;
      logic down_write;
      logic down_final;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      kind_type kind;
      logic     full;
      logic     empty;
      logic     pend_hit;
      logic     scan_end;
      logic     j_gt_pos;
      logic     j_lt_occ;
      logic     rsp_free;
   } stat_type;

endpackage

// ===== rtl/ordered_list_engine.sv =====
// Top level of the ordered list engine: controller, datapath and entry memory.
//
//   channel  direction  contents
//   req      in         tuser = kind, tdata = value
//   rsp      out        tdata = status, found, entry count, min, max
//
// Each request ends with a pass over the entries that finds the minimum and
// maximum, and then with the result. A push, insert or pop also moves entries,
// and every move reads and then writes the entry memory, which has one write
// port and one read port with registered read data; an insert or a search
// first scans the entries front to back. Reset clears the count and the
// handshakes; memory contents are not cleared. A stalled result waits in its
// register, and the next request is taken once the current one has been
// handed to that register.
module ordered_list_engine #(
   parameter int CAPACITY = ole_pkg::CAPACITY_DEF,
   parameter int CW = $clog2(CAPACITY + 1),
   parameter int RSP_W = ((ole_pkg::STATUS_W + 1 + CW + 2 * ole_pkg::VALUE_W + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ole_pkg::VALUE_W-1:0]     req_tdata,   // value
   input  logic [ole_pkg::KIND_W-1:0]      req_tuser,   // kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [RSP_W-1:0]                rsp_tdata    // status, found, count, min, max
);

   ole_pkg::cmd_type  cmd;
   ole_pkg::stat_type stat;

   ole_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   ole_dp #(
      .CAPACITY (CAPACITY),
      .CW       (CW),
      .RSP_W    (RSP_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_kind   (req_tuser),
      .req_value  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/ole_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ole_dp.sv =====
// Datapath: entry memory, counters, compares, extremes and result register.
module ole_dp #(
   parameter int CAPACITY = ole_pkg::CAPACITY_DEF,
   parameter int CW = $clog2(CAPACITY + 1),
   parameter int RSP_W = ((ole_pkg::STATUS_W + 1 + CW + 2 * ole_pkg::VALUE_W + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ole_pkg::cmd_type                 cmd,
   output ole_pkg::stat_type                stat,
   input  logic [ole_pkg::KIND_W-1:0]       req_kind,
   input  logic [ole_pkg::VALUE_W-1:0]      req_value,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RSP_W-1:0]                 rsp_tdata
);

   localparam int AW = $clog2(CAPACITY);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   ole_pkg::kind_type                   kind_ff, kind_in;
   logic signed [ole_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic [ole_pkg::STATUS_W-1:0]        status_ff, status_in;
   logic                                found_ff, found_in;
   logic [CW-1:0]                       occ_ff, occ_in;
   logic [CW-1:0]                       idx_ff, idx_in;
   logic [CW-1:0]                       j_ff, j_in;
   logic [CW-1:0]                       pos_ff, pos_in;
   logic                                pend_ff, pend_in;
   logic [AW-1:0]                       pend_idx_ff, pend_idx_in;
   logic                                first_ff, first_in;
   logic signed [ole_pkg::VALUE_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ole_pkg::STATUS_W-1:0]        rsp_status_ff;
   logic                                rsp_found_ff;
   logic [CW-1:0]                       rsp_count_ff;
   logic signed [ole_pkg::VALUE_W-1:0]  rsp_lo_ff, rsp_hi_ff;

   logic                                wr_en;
   logic [AW-1:0]                       wr_addr, rd_addr;
   logic [ole_pkg::VALUE_W-1:0]         wr_data, rd_raw;
   logic signed [ole_pkg::VALUE_W-1:0]  rd_data;
   logic                                hit_cmp;
   logic [CW-1:0]                       j_dec;

   ole_ram #(
      .WIDTH (ole_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_data = $signed(rd_raw);
   assign j_dec = j_ff - CW'(1);

   // Compare of the word read last cycle against the request value.
   always_comb begin
      if (kind_ff == ole_pkg::KIND_INSERT) begin
         hit_cmp = (rd_data >= value_ff);
      end else begin
         hit_cmp = (rd_data == value_ff);
      end
   end

   // Memory port selection.
   always_comb begin
      if (cmd.up_read) begin
         rd_addr = j_dec[AW-1:0];
      end else if (cmd.down_read) begin
         rd_addr = j_ff[AW-1:0];
      end else begin
         rd_addr = idx_ff[AW-1:0];
      end
      wr_en = cmd.up_write | cmd.up_final | cmd.down_write;
      if (cmd.up_final) begin
         wr_addr = pos_ff[AW-1:0];
         wr_data = value_ff;
      end else if (cmd.down_write) begin
         wr_addr = j_dec[AW-1:0];
         wr_data = rd_raw;
      end else begin
         wr_addr = j_ff[AW-1:0];
         wr_data = rd_raw;
      end
   end

   // Next-state logic of the datapath registers.
   always_comb begin
      kind_in      = kind_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      occ_in       = occ_ff;
      idx_in       = idx_ff;
      j_in         = j_ff;
      pos_in       = pos_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      first_in     = first_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.load) begin
         kind_in   = ole_pkg::kind_type'(req_kind);
         value_in  = $signed(req_value);
         status_in = ole_pkg::STAT_DONE;
         found_in  = 1'b0;
      end
      if (cmd.set_full) begin
         status_in = ole_pkg::STAT_FULL;
      end
      if (cmd.set_empty) begin
         status_in = ole_pkg::STAT_EMPTY;
      end
      if (cmd.pos_zero) begin
         pos_in = '0;
      end

      // Scan: issue one read per cycle, look at the word issued before.
      if (cmd.scan_step) begin
         pend_in = 1'b0;
         if (idx_ff < occ_ff) begin
            pend_in     = 1'b1;
            pend_idx_in = idx_ff[AW-1:0];
            idx_in      = idx_ff + CW'(1);
         end
         if (pend_ff) begin
            first_in = 1'b0;
            if (first_ff || rd_data < lo_ff) begin
               lo_in = rd_data;
            end
            if (first_ff || rd_data > hi_ff) begin
               hi_in = rd_data;
            end
         end
      end
      if (cmd.scan_start) begin
         idx_in   = '0;
         pend_in  = 1'b0;
         first_in = 1'b1;
         lo_in    = '0;
         hi_in    = '0;
      end

      if (cmd.find_take) begin
         if (pend_ff && hit_cmp) begin
            pos_in   = CW'(pend_idx_ff);
            found_in = (kind_ff == ole_pkg::KIND_SEARCH);
         end else begin
            pos_in = occ_ff;
         end
      end

      // Shift steps.
      if (cmd.up_start) begin
         j_in = occ_ff;
      end
      if (cmd.up_write) begin
         j_in = j_dec;
      end
      if (cmd.up_final) begin
         occ_in = occ_ff + CW'(1);
      end
      if (cmd.down_start) begin
         j_in = CW'(1);
      end
      if (cmd.down_write) begin
         j_in = j_ff + CW'(1);
      end
      if (cmd.down_final) begin
         occ_in = occ_ff - CW'(1);
      end

      // Result register handshake.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      idx_ff      <= idx_in;
      j_ff        <= j_in;
      pos_ff      <= pos_in;
      pend_idx_ff <= pend_idx_in;
      first_ff    <= first_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_count_ff  <= occ_ff;
         rsp_lo_ff     <= lo_ff;
         rsp_hi_ff     <= hi_ff;
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.kind     = kind_ff;
      stat.full     = (occ_ff == FULL_COUNT);
      stat.empty    = (occ_ff == '0);
      stat.pend_hit = pend_ff && hit_cmp;
      stat.scan_end = !pend_ff && (idx_ff >= occ_ff);
      stat.j_gt_pos = (j_ff > pos_ff);
      stat.j_lt_occ = (j_ff < occ_ff);
      stat.rsp_free = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_hi_ff, rsp_lo_ff, rsp_count_ff, rsp_found_ff, rsp_status_ff});

endmodule

// ===== rtl/ole_ctrl.sv =====
// Controller: sequences scans and shifts of one request at a time.
module ole_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ole_pkg::KIND_W-1:0]  req_kind,
   input  ole_pkg::stat_type           stat,
   output ole_pkg::cmd_type            cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_FIND   = 8'b00000010,
      ST_UP_RD  = 8'b00000100,
      ST_UP_WR  = 8'b00001000,
      ST_DN_RD  = 8'b00010000,
      ST_DN_WR  = 8'b00100000,
      ST_MINMAX = 8'b01000000,
      ST_DONE   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   ole_pkg::kind_type kind;

   assign kind = ole_pkg::kind_type'(req_kind);
   assign req_tready = (state_ff == ST_IDLE);

   // State transitions and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if ((kind == ole_pkg::KIND_PUSH || kind == ole_pkg::KIND_INSERT) && stat.full) begin
                  cmd.set_full   = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = ST_MINMAX;
               end else if (kind == ole_pkg::KIND_POP && stat.empty) begin
                  cmd.set_empty  = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = ST_MINMAX;
               end else if (kind == ole_pkg::KIND_PUSH) begin
                  cmd.pos_zero = 1'b1;
                  cmd.up_start = 1'b1;
                  state_in     = ST_UP_RD;
               end else if (kind == ole_pkg::KIND_POP) begin
                  cmd.down_start = 1'b1;
                  state_in       = ST_DN_RD;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (stat.pend_hit || stat.scan_end) begin
               cmd.find_take = 1'b1;
               if (stat.kind == ole_pkg::KIND_SEARCH) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_MINMAX;
               end else begin
                  cmd.up_start = 1'b1;
                  state_in     = ST_UP_RD;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_UP_RD: begin
            if (stat.j_gt_pos) begin
               cmd.up_read = 1'b1;
               state_in    = ST_UP_WR;
            end else begin
               cmd.up_final   = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_MINMAX;
            end
         end
         ST_UP_WR: begin
            cmd.up_write = 1'b1;
            state_in     = ST_UP_RD;
         end
         ST_DN_RD: begin
            if (stat.j_lt_occ) begin
               cmd.down_read = 1'b1;
               state_in      = ST_DN_WR;
            end else begin
               cmd.down_final = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_MINMAX;
            end
         end
         ST_DN_WR: begin
            cmd.down_write = 1'b1;
            state_in       = ST_DN_RD;
         end
         ST_MINMAX: begin
            if (stat.scan_end) begin
               state_in = ST_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== tb/ordered_list_engine_tb.sv =====
// Testbench of the ordered list engine: directed table, random traffic, predictor check.
module ordered_list_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = 32;
   localparam int CW = $clog2(CAP + 1);
   localparam int RSP_W = ((ole_pkg::STATUS_W + 1 + CW + 2 * ole_pkg::VALUE_W + 7) / 8) * 8;
   localparam int IDLE_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1950;

   typedef struct packed {
      logic signed [ole_pkg::VALUE_W-1:0] max_value;
      logic signed [ole_pkg::VALUE_W-1:0] min_value;
      logic [CW-1:0]                      entry_count;
      logic                               found;
      logic [ole_pkg::STATUS_W-1:0]       status;
   } result_type;

   // One row of the directed table; check_typed marks a hand-written result.
   typedef struct {
      ole_pkg::kind_type  kind;
      logic signed [31:0] value;
      logic               check_typed;
      result_type         typed;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ole_pkg::VALUE_W-1:0] req_tdata = '0;
   logic [ole_pkg::KIND_W-1:0] req_tuser = ole_pkg::KIND_PUSH;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   // Predictor state.
   logic signed [31:0] shadow_list [CAP];
   int unsigned shadow_count;
   result_type pending_results [$];
   int unsigned error_count;
   int unsigned idle_cycles;
   bit stimulus_done;

   ordered_list_engine #(.CAPACITY(CAP)) u_dut (.*);

   always #5 clock = ~clock;

   function automatic result_type entry(logic [1:0] st, logic fnd, int cnt,
                                        int lo, int hi);
      result_type r;
      r.status = st;
      r.found = fnd;
      r.entry_count = CW'(cnt);
      r.min_value = lo;
      r.max_value = hi;
      return r;
   endfunction

   // Applies one request to the shadow list and returns the result it causes.
   function automatic result_type apply_request(ole_pkg::kind_type kind,
                                                logic signed [31:0] v);
      result_type r;
      int unsigned pos;
      r = '0;
      r.status = ole_pkg::STAT_DONE;
      case (kind)
         ole_pkg::KIND_PUSH, ole_pkg::KIND_INSERT: begin
            if (shadow_count >= CAP) begin
               r.status = ole_pkg::STAT_FULL;
            end else begin
               pos = 0;
               if (kind == ole_pkg::KIND_INSERT) begin
                  pos = shadow_count;
                  for (int i = shadow_count - 1; i >= 0; i--)
                     if (shadow_list[i] >= v) pos = i;
               end
               for (int i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[pos] = v;
               shadow_count++;
            end
         end
         ole_pkg::KIND_POP: begin
            if (shadow_count == 0) begin
               r.status = ole_pkg::STAT_EMPTY;
            end else begin
               for (int i = 1; i < shadow_count; i++) shadow_list[i-1] = shadow_list[i];
               shadow_count--;
            end
         end
         default: begin
            for (int i = 0; i < shadow_count; i++)
               if (shadow_list[i] == v) r.found = 1'b1;
         end
      endcase
      if (shadow_count > 0) begin
         r.min_value = shadow_list[0];
         r.max_value = shadow_list[0];
         for (int i = 1; i < shadow_count; i++) begin
            if (shadow_list[i] < r.min_value) r.min_value = shadow_list[i];
            if (shadow_list[i] > r.max_value) r.max_value = shadow_list[i];
         end
      end
      r.entry_count = CW'(shadow_count);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Drives one word at the falling edge and holds it until it is taken.
   task automatic send_word(ole_pkg::kind_type kind, logic signed [31:0] v,
                            result_type want, bit use_typed);
      result_type predicted;
      predicted = apply_request(kind, v);
      if (use_typed && predicted != want)
         report_mismatch("table row vs predictor", predicted, want);
      pending_results.push_back(use_typed ? want : predicted);
      req_tuser <= kind;
      req_tdata <= v;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Values that stress signed compares and duplicates.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $signed(32'($urandom_range(0, 15))) - 8;
         default: return $urandom;
      endcase
   endfunction

   // Result checker and watchdog.
   always @(posedge clock) begin
      result_type got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected word", got, 0);
            end else begin
               want = pending_results.pop_front();
               if (got.status != want.status) report_mismatch("status", got.status, want.status);
               if (got.found != want.found) report_mismatch("found", got.found, want.found);
               if (got.entry_count != want.entry_count)
                  report_mismatch("entry_count", got.entry_count, want.entry_count);
               if (got.min_value != want.min_value)
                  report_mismatch("min_value", got.min_value, want.min_value);
               if (got.max_value != want.max_value)
                  report_mismatch("max_value", got.max_value, want.max_value);
            end
         end
      end
   end

   // Receiver stalls at random, and is always ready once the stimulus is done.
   always @(negedge clock) begin
      int unsigned phase;
      phase = $urandom_range(0, 15);
      if (stimulus_done) rsp_tready <= 1'b1;
      else if (phase < 4) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   initial begin
      row_type directed [$];
      int unsigned burst;
      ole_pkg::kind_type kind;
      int unsigned goal;
      error_count = 0;
      idle_cycles = 0;
      stimulus_done = 0;
      shadow_count = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty pop, extremes, equal values, search hit and miss.
      directed.push_back('{ole_pkg::KIND_POP, 0, 1,
                           entry(ole_pkg::STAT_EMPTY, 0, 0, 0, 0)});
      directed.push_back('{ole_pkg::KIND_SEARCH, 0, 1,
                           entry(ole_pkg::STAT_DONE, 0, 0, 0, 0)});
      directed.push_back('{ole_pkg::KIND_INSERT, 32'sh7fff_ffff, 1,
                           entry(ole_pkg::STAT_DONE, 0, 1, 32'sh7fff_ffff, 32'sh7fff_ffff)});
      directed.push_back('{ole_pkg::KIND_PUSH, 32'sh8000_0000, 1,
                           entry(ole_pkg::STAT_DONE, 0, 2, 32'sh8000_0000, 32'sh7fff_ffff)});
      directed.push_back('{ole_pkg::KIND_INSERT, -1, 0, '0});
      directed.push_back('{ole_pkg::KIND_INSERT, -1, 0, '0});
      directed.push_back('{ole_pkg::KIND_PUSH, 5, 0, '0});
      directed.push_back('{ole_pkg::KIND_INSERT, 3, 0, '0});
      directed.push_back('{ole_pkg::KIND_SEARCH, -1, 0, '0});
      directed.push_back('{ole_pkg::KIND_SEARCH, 4, 0, '0});
      directed.push_back('{ole_pkg::KIND_POP, 0, 0, '0});
      directed.push_back('{ole_pkg::KIND_POP, 0, 0, '0});
      directed.push_back('{ole_pkg::KIND_POP, 0, 0, '0});
      directed.push_back('{ole_pkg::KIND_POP, 0, 0, '0});
      directed.push_back('{ole_pkg::KIND_POP, 0, 0, '0});
      directed.push_back('{ole_pkg::KIND_POP, 0, 0, '0});
      directed.push_back('{ole_pkg::KIND_POP, 0, 1,
                           entry(ole_pkg::STAT_EMPTY, 0, 0, 0, 0)});
      foreach (directed[i])
         send_word(directed[i].kind, directed[i].value, directed[i].typed,
                   directed[i].check_typed);

      // Fill to capacity, overflow both kinds, then drain.
      for (int i = 0; i < CAP; i++) send_word(ole_pkg::KIND_INSERT, pick_value(), '0, 0);
      send_word(ole_pkg::KIND_PUSH, 1, '0, 0);
      send_word(ole_pkg::KIND_INSERT, 1, '0, 0);
      send_word(ole_pkg::KIND_SEARCH, 32'sh8000_0000, '0, 0);
      for (int i = 0; i <= CAP; i++) send_word(ole_pkg::KIND_POP, 0, '0, 0);

      // Random part: bursts with random gaps, with a drift toward fill or drain.
      goal = 0;
      for (int n = 0; n < RANDOM_ITEMS; ) begin
         if ($urandom_range(0, 63) == 0) goal = $urandom_range(0, 1) ? CAP : 0;
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++, n++) begin
            case ($urandom_range(0, 3))
               0: kind = (shadow_count < goal) ? ole_pkg::KIND_INSERT : ole_pkg::KIND_POP;
               1: kind = (shadow_count < goal) ? ole_pkg::KIND_PUSH : ole_pkg::KIND_POP;
               default: kind = ole_pkg::kind_type'($urandom_range(0, 3));
            endcase
            send_word(kind, pick_value(), '0, 0);
         end
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;
      stimulus_done = 1;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule
